### hw/rtl/rdf_pkg.sv
// shared widths, register map, reset values and character constants of the radix digit formatter
package rdf_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 64;
  localparam int COUNT_W    = 7;
  localparam int PTR_W      = 6;
  localparam int BYTE_W     = 3;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int REG_SEL_W  = 2;

  localparam logic [REG_SEL_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_ALPHA_LOW = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_ALPHA_HI  = 2'd2;

  localparam logic [RADIX_W-1:0]    RADIX_RST     = 5'd10;
  localparam logic [VALUE_W-1:0]    ALPHA_LOW_RST = 64'h3736_3534_3332_3130;
  localparam logic [VALUE_W-1:0]    ALPHA_HI_RST  = 64'h4645_4443_4241_3938;
  localparam logic [CHAR_W-1:0]     ZERO_CHAR     = 8'h30;
  localparam logic [CHAR_W-1:0]     BAD_CHAR      = 8'h00;

endpackage

### hw/rtl/radix_digit_formatter.sv
// radix digit formatter: unsigned 64-bit value to a character string in a configured radix
//
// input channel in_valid / in_stall / in_value; a transfer takes one value to convert.
// result channel out_valid / out_stall with out_character, out_last, out_bad_base; one
// transfer per character, most significant digit first, out_last on the final one.
// a zero value gives the single character "0"; otherwise a radix outside 2..16 or an
// alphabet with repeated characters among the ones in use gives one out_bad_base result.
// registers radix, alphabet_low, alphabet_high sit on the apb port at 0x00, 0x08, 0x10.
// per value: the transfer, then the alphabet check, one character per step on the shared
// byte comparator row, then for every digit one step per significant quotient byte
// (the shared 8-bit long-division step), then one character at a time through the
// digit store read port. the first character passes from its store read through the
// read stage into the output register.
// in_stall is high from the transfer until the last character has reached the output
// register, so a finished character may wait there while the next value is taken.
// when the receiver stalls, the output register and one read stage hold and the
// digit sequencer pauses. reset empties both and returns to idle; registers reload.
module radix_digit_formatter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rdf_pkg::VALUE_W-1:0]       in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rdf_pkg::CHAR_W-1:0]        out_character,
  output logic                              out_last,
  output logic                              out_bad_base,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rdf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rdf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rdf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic [RADIX_W-1:0]   radix_r;
  logic [VALUE_W-1:0]   alpha_low_r;
  logic [VALUE_W-1:0]   alpha_hi_r;
  logic [VALUE_W-1:0]   quo_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [BYTE_W-1:0]    top_r;
  logic [BYTE_W-1:0]    top_nxt;
  logic                 top_zero_r;
  logic                 top_zero;
  logic [DIGIT_W-1:0]   chk_i_r;
  logic [COUNT_W-1:0]   count_r;
  logic [PTR_W-1:0]     ptr_r;
  logic                 rd_valid_r;
  logic                 rd_zero_r;
  logic                 rd_bad_r;
  logic                 rd_last_r;
  logic [DIGIT_W-1:0]   rd_digit_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_character_r;
  logic                 out_last_r;
  logic                 out_bad_base_r;
  logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];

  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;
  logic                 in_acc;
  logic                 load;
  logic                 issue;
  logic                 radix_ok;
  logic                 dup;
  logic                 chk_done;
  logic [BYTE_W-1:0]    in_top;
  logic [CHAR_W-1:0]    qbyte;
  logic [DIGIT_W-1:0]   rem_step;
  logic [VALUE_W-1:0]   quo_upd;
  logic                 digit_end;
  logic [CHAR_W-1:0]    char_sel;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [VALUE_W-1:0] lo,
                                                   input logic [VALUE_W-1:0] hi,
                                                   input logic [DIGIT_W-1:0] k);
    logic [VALUE_W-1:0] word;
    word = k[DIGIT_W-1] ? hi : lo;
    return word[{k[DIGIT_W-2:0], 3'b000} +: CHAR_W];
  endfunction

  // one long-division step over a dividend byte, one bit per inner step
  function automatic logic [CHAR_W+DIGIT_W-1:0] div_byte(input logic [DIGIT_W-1:0] rem_in,
                                                         input logic [CHAR_W-1:0]  dvd,
                                                         input logic [RADIX_W-1:0] dvs);
    logic [RADIX_W-1:0] t;
    logic [CHAR_W-1:0]  q;
    logic [DIGIT_W-1:0] rem;
    rem = rem_in;
    q   = '0;
    for (int b = CHAR_W - 1; b >= 0; b--) begin
      t = {rem, dvd[b]};
      if (t >= dvs) begin
        t    = t - dvs;
        q[b] = 1'b1;
      end
      rem = t[DIGIT_W-1:0];
    end
    return {q, rem};
  endfunction

  assign pready        = 1'b1;
  assign reg_sel       = paddr[APB_ADDR_W-1 -: REG_SEL_W];
  assign wr_en         = psel & penable & pwrite;
  assign in_stall      = (state_r != S_IDLE) | rd_valid_r;
  assign in_acc        = in_valid & ~in_stall;
  assign load          = rd_valid_r & (~out_valid_r | ~out_stall);
  assign issue         = (state_r == S_EMIT) & (~rd_valid_r | load);
  assign radix_ok      = (radix_r >= 5'd2) && (radix_r <= RADIX_W'(MAX_RADIX));
  assign chk_done      = ({1'b0, chk_i_r} + 5'd2) >= radix_r;
  assign digit_end     = (state_r == S_DIV) && (byte_r == '0);
  assign top_zero      = (byte_r == top_r) ? (qbyte == '0) : top_zero_r;
  assign top_nxt       = (top_zero && (top_r != '0)) ? top_r - 3'd1 : top_r;
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_bad_base  = out_bad_base_r;

  always_comb begin
    case (reg_sel)
      REG_RADIX:     prdata = {{(APB_DATA_W-RADIX_W){1'b0}}, radix_r};
      REG_ALPHA_LOW: prdata = alpha_low_r;
      REG_ALPHA_HI:  prdata = alpha_hi_r;
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((RADIX_W'(j) > {1'b0, chk_i_r}) && (RADIX_W'(j) < radix_r) &&
          (alpha_char(alpha_low_r, alpha_hi_r, DIGIT_W'(j)) ==
           alpha_char(alpha_low_r, alpha_hi_r, chk_i_r))) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    in_top = '0;
    for (int i = 0; i < VALUE_W / CHAR_W; i++) begin
      if (|in_value[i*CHAR_W +: CHAR_W]) begin
        in_top = BYTE_W'(i);
      end
    end
  end

  always_comb begin
    {qbyte, rem_step} = div_byte(rem_r, quo_r[{byte_r, 3'b000} +: CHAR_W], radix_r);
    quo_upd = quo_r;
    quo_upd[{byte_r, 3'b000} +: CHAR_W] = qbyte;
  end

  always_comb begin
    if (rd_bad_r) begin
      char_sel = BAD_CHAR;
    end else if (rd_zero_r) begin
      char_sel = ZERO_CHAR;
    end else begin
      char_sel = alpha_char(alpha_low_r, alpha_hi_r, rd_digit_r);
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (digit_end) begin
      digit_mem[count_r[PTR_W-1:0]] <= rem_step;
    end
    if (issue) begin
      rd_digit_r <= digit_mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      radix_r     <= RADIX_RST;
      alpha_low_r <= ALPHA_LOW_RST;
      alpha_hi_r  <= ALPHA_HI_RST;
    end else begin
      if (wr_en) begin
        case (reg_sel)
          REG_RADIX:     radix_r     <= pwdata[RADIX_W-1:0];
          REG_ALPHA_LOW: alpha_low_r <= pwdata;
          REG_ALPHA_HI:  alpha_hi_r  <= pwdata;
          default: ;
        endcase
      end

      if (load) begin
        out_valid_r     <= 1'b1;
        out_character_r <= char_sel;
        out_last_r      <= rd_last_r;
        out_bad_base_r  <= rd_bad_r;
        if (!issue) begin
          rd_valid_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_value == '0) begin
              rd_valid_r <= 1'b1;
              rd_zero_r  <= 1'b1;
              rd_bad_r   <= 1'b0;
              rd_last_r  <= 1'b1;
              count_r    <= '0;
              quo_r      <= '0;
            end else if (!radix_ok) begin
              rd_valid_r <= 1'b1;
              rd_zero_r  <= 1'b0;
              rd_bad_r   <= 1'b1;
              rd_last_r  <= 1'b1;
            end else begin
              quo_r   <= in_value;
              byte_r  <= in_top;
              top_r   <= in_top;
              rem_r   <= '0;
              chk_i_r <= '0;
              count_r <= '0;
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          chk_i_r <= chk_i_r + 4'd1;
          if (dup) begin
            rd_valid_r <= 1'b1;
            rd_zero_r  <= 1'b0;
            rd_bad_r   <= 1'b1;
            rd_last_r  <= 1'b1;
            state_r    <= S_IDLE;
          end else if (chk_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          quo_r <= quo_upd;
          if (byte_r == top_r) begin
            top_zero_r <= (qbyte == '0);
          end
          if (byte_r == '0) begin
            count_r <= count_r + 7'd1;
            rem_r   <= '0;
            if ((quo_upd == '0) || (count_r == COUNT_W'(MAX_DIGITS - 1))) begin
              ptr_r   <= count_r[PTR_W-1:0];
              state_r <= S_EMIT;
            end else begin
              byte_r <= top_nxt;
              top_r  <= top_nxt;
            end
          end else begin
            rem_r  <= rem_step;
            byte_r <= byte_r - 3'd1;
          end
        end
        S_EMIT: begin
          if (issue) begin
            rd_valid_r <= 1'b1;
            rd_zero_r  <= 1'b0;
            rd_bad_r   <= 1'b0;
            rd_last_r  <= (ptr_r == '0);
            ptr_r      <= ptr_r - 6'd1;
            if (ptr_r == '0) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/rdf_checker.sv
// port-level checks of the radix digit formatter and their bind to the top level
module rdf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rdf_pkg::CHAR_W-1:0] out_character,
  input logic                       out_last,
  input logic                       out_bad_base
);
  import rdf_pkg::*;

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a value transfer always makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // a bad base result is a single null character
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last && (out_character == BAD_CHAR))
    else $error("bad base result malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character) &&
                               $stable(out_last) && $stable(out_bad_base))
    else $error("stalled result changed");

endmodule

bind radix_digit_formatter rdf_checker u_rdf_checker (.*);

### dv/tb_radix_digit_formatter.sv
// testbench for the radix digit formatter: directed and random values checked against a predictor
`timescale 1ns / 100ps

module tb_radix_digit_formatter;
  import rdf_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;
  } char_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_W-1:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_last;
  logic                  out_bad_base;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [RADIX_W-1:0] cur_radix = RADIX_RST;
  logic [VALUE_W-1:0] alpha_lo = ALPHA_LOW_RST;
  logic [VALUE_W-1:0] alpha_hi = ALPHA_HI_RST;

  char_result_t pending_chars[$];

  int values_sent = 0;
  int chars_seen = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  radix_digit_formatter uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last),
    .out_bad_base (out_bad_base),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [VALUE_W-1:0] half;
    half = d[3] ? alpha_hi : alpha_lo;
    return half[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

  function automatic bit base_usable();
    if (cur_radix < 2 || cur_radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < cur_radix; i++)
      for (int j = i + 1; j < cur_radix; j++)
        if (glyph(DIGIT_W'(i)) == glyph(DIGIT_W'(j))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_string(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    int n;
    if (v == '0) begin
      pending_chars.push_back(char_result_t'{ZERO_CHAR, 1'b1, 1'b0});
    end else if (!base_usable()) begin
      pending_chars.push_back(char_result_t'{BAD_CHAR, 1'b1, 1'b1});
    end else begin
      q = v;
      n = 0;
      while (q != '0 && n < MAX_DIGITS) begin
        digits[n] = DIGIT_W'(q % VALUE_W'(cur_radix));
        q = q / VALUE_W'(cur_radix);
        n++;
      end
      for (int k = n - 1; k >= 0; k--)
        pending_chars.push_back(char_result_t'{glyph(digits[k]), k == 0, 1'b0});
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return VALUE_W'($urandom_range(1, 255));
      2, 3: return full;
      default: return full >> $urandom_range(1, 63);
    endcase
  endfunction

  // result side: compare each transfer, drive random stall, watchdog count
  always @(posedge clk) begin : result_check
    char_result_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected character %h last %b bad_base %b",
                     out_character, out_last, out_bad_base);
        end else begin
          want = pending_chars.pop_front();
          if (out_character !== want.character || out_last !== want.last ||
              out_bad_base !== want.bad_base) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: mismatch expected char %h last %b bad_base %b, got %h %b %b",
                       want.character, want.last, want.bad_base,
                       out_character, out_last, out_bad_base);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: watchdog expired after %0d cycles with no transfer", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    predict_string(v);
    values_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_SEL_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIX:     cur_radix = data[RADIX_W-1:0];
      REG_ALPHA_LOW: alpha_lo = data;
      REG_ALPHA_HI:  alpha_hi = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_base(input logic [RADIX_W-1:0] r, input logic [VALUE_W-1:0] lo,
                          input logic [VALUE_W-1:0] hi);
    logic [APB_DATA_W-1:0] rword;
    wait_drained();
    rword = {$urandom, $urandom};
    rword[RADIX_W-1:0] = r;
    write_reg(REG_RADIX, rword);
    write_reg(REG_ALPHA_LOW, lo);
    write_reg(REG_ALPHA_HI, hi);
  endtask

  task automatic pick_setting();
    logic [RADIX_W-1:0] r;
    logic [CHAR_W-1:0] chars[MAX_RADIX];
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    bit clash;
    int a;
    int b;
    if ($urandom_range(9) < 8) begin
      r = RADIX_W'($urandom_range(2, MAX_RADIX));
    end else begin
      case ($urandom_range(2))
        0: r = '0;
        1: r = 5'd1;
        default: r = RADIX_W'($urandom_range(17, 31));
      endcase
    end
    for (int i = 0; i < MAX_RADIX; i++) begin
      do begin
        chars[i] = CHAR_W'($urandom_range(255));
        clash = 1'b0;
        for (int j = 0; j < i; j++)
          if (chars[j] == chars[i]) clash = 1'b1;
      end while (clash);
    end
    if (r >= 2 && r <= MAX_RADIX && $urandom_range(9) == 0) begin
      a = $urandom_range(r - 1);
      do b = $urandom_range(r - 1); while (b == a);
      chars[b] = chars[a];
    end
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = chars[i];
      hi[8*i +: 8] = chars[i+8];
    end
    set_base(r, lo, hi);
  endtask

  task automatic test_default_decimal();
    send_value('0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
  endtask

  task automatic test_radix_extremes();
    set_base(5'd2, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd1);
    set_base(5'd16, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value('1);
    send_value(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_unusable_base();
    set_base(5'd0, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value(64'd5);
    set_base(5'd1, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value(64'd7);
    send_value('0);
    set_base(5'd17, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value(64'd3);
    set_base(5'd31, ALPHA_LOW_RST, ALPHA_HI_RST);
    send_value('1);
    // first and last characters equal, far apart
    set_base(5'd16, ALPHA_LOW_RST, {8'h30, ALPHA_HI_RST[55:0]});
    send_value(64'd123);
    send_value('0);
  endtask

  task automatic test_alphabet_edges();
    // repeats only beyond the radix in use
    set_base(5'd3, 64'h5858_5858_5858_3130, 64'h5858_5858_5858_5858);
    send_value(64'd100);
    // zero byte as digit zero
    set_base(5'd8, 64'h3736_3534_3332_3100, ALPHA_HI_RST);
    send_value(64'd64);
    set_base(5'd16, 64'hF8F9_FAFB_FCFD_FEFF, 64'h0001_0203_0405_0607);
    send_value(64'hFEDC_BA98_7654_3210);
    set_base(RADIX_RST, ALPHA_LOW_RST, ALPHA_HI_RST);
  endtask

  task automatic test_random_values(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int s = 0; s < 2; s++) begin
      pick_setting();
      for (int i = 0; i < count / 2; i++)
        send_value(rand_value());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_decimal();
    test_radix_extremes();
    test_unusable_base();
    test_alphabet_edges();
    test_random_values(24, 0, 0);
    test_random_values(24, 70, 0);
    test_random_values(24, 0, 70);
    test_random_values(24, 33, 33);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) mismatches++;
    $display("tb: %0d values converted into %0d checked characters, %0d register writes",
             values_sent, chars_seen, reg_writes);
    $display("tb: %0d mismatches over four pacing phases", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
